// ===== sv/betb_pkg.sv =====
// Shared types and constants for the button edge and auto-repeat table.
package betb_pkg;

  localparam int unsigned IDX_W   = 6;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned TIMER_W = TIME_W + 1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INPUTS_BLOCKED  = 2'd2;

  // Register reset values (0.48 s and 0.07 s in microseconds).
  localparam logic [TIME_W-1:0] REPEAT_DELAY_RST    = 24'd480000;
  localparam logic [TIME_W-1:0] REPEAT_INTERVAL_RST = 24'd70000;

  // Lower bound of the repeat timer.
  localparam logic signed [TIMER_W:0] TIMER_MIN = -26'sd16777216;

  // Event codes; the unused code means no new event.
  typedef enum logic [KIND_W-1:0] {
    EV_RELEASE = 2'd0,
    EV_PRESS   = 2'd1,
    EV_NONE    = 2'd2
  } event_t;

  // Per-button flags as stored in the table.
  typedef struct packed {
    logic typed;
    logic toggle;
    logic released;
    logic pressed;
    logic held;
  } flags_t;

  // One table entry: flags and the signed repeat timer.
  typedef struct packed {
    flags_t                      flags;
    logic signed [TIMER_W-1:0]   timer;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

// ===== sv/betb_req_if.sv =====
// Input channel: one button update item per handshake.
interface betb_req_if;
  logic                               valid;
  logic                               ready;
  logic [betb_pkg::IDX_W-1:0]         button_index;
  logic [betb_pkg::KIND_W-1:0]        event_kind;
  logic [betb_pkg::TIME_W-1:0]        elapsed_us;

  modport source (output valid, output button_index, output event_kind,
                  output elapsed_us, input ready);
  modport sink   (input valid, input button_index, input event_kind,
                  input elapsed_us, output ready);
endinterface

// ===== sv/betb_rsp_if.sv =====
// Output channel: one button status item per handshake.
interface betb_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [betb_pkg::IDX_W-1:0] button_id;
  logic                       is_held;
  logic                       was_pressed;
  logic                       was_released;
  logic                       toggle_state;
  logic                       typed_pulse;

  modport source (output valid, output button_id, output is_held, output was_pressed,
                  output was_released, output toggle_state, output typed_pulse,
                  input ready);
  modport sink   (input valid, input button_id, input is_held, input was_pressed,
                  input was_released, input toggle_state, input typed_pulse,
                  output ready);
endinterface

// ===== sv/betb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module betb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; a read at the address being written returns old data.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/betb_update.sv =====
// Next-entry logic: edge flags, toggle and the typematic repeat timer.
module betb_update (
  input  betb_pkg::entry_t                   cur,
  input  logic [betb_pkg::KIND_W-1:0]        event_kind,
  input  logic [betb_pkg::TIME_W-1:0]        elapsed_us,
  input  logic [betb_pkg::TIME_W-1:0]        repeat_delay_us,
  input  logic [betb_pkg::TIME_W-1:0]        repeat_interval_us,
  output betb_pkg::entry_t                   nxt
);

  logic                                      is_press;
  logic                                      is_release;
  logic                                      held_n;
  logic                                      pressed_n;
  logic signed [betb_pkg::TIMER_W:0]         diff;
  logic signed [betb_pkg::TIMER_W:0]         clamped;
  logic signed [betb_pkg::TIMER_W:0]         raised;

  // Decode the event; the spare code acts as no new event.
  always_comb begin
    is_press   = (event_kind == betb_pkg::EV_PRESS);
    is_release = (event_kind == betb_pkg::EV_RELEASE);
    pressed_n  = is_press && !cur.flags.held;
    if (is_press) begin
      held_n = 1'b1;
    end else if (is_release) begin
      held_n = 1'b0;
    end else begin
      held_n = cur.flags.held;
    end
  end

  // Count down by the frame time, clamp at the lower bound, then reload once.
  always_comb begin
    diff    = 26'(cur.timer) - $signed({2'b00, elapsed_us});
    clamped = (diff < betb_pkg::TIMER_MIN) ? betb_pkg::TIMER_MIN : diff;
    raised  = clamped + $signed({2'b00, repeat_interval_us});
  end

  // Assemble the new entry.
  always_comb begin
    nxt.flags.held     = held_n;
    nxt.flags.pressed  = pressed_n;
    nxt.flags.released = is_release;
    nxt.flags.toggle   = cur.flags.toggle ^ pressed_n;
    nxt.flags.typed    = 1'b0;
    nxt.timer          = '0;
    if (pressed_n) begin
      nxt.flags.typed = 1'b1;
      nxt.timer       = $signed({1'b0, repeat_delay_us});
    end else if (held_n) begin
      if (clamped[betb_pkg::TIMER_W]) begin
        // The sum stays below the upper bound, so no upper clamp is needed.
        nxt.flags.typed = 1'b1;
        nxt.timer       = raised[betb_pkg::TIMER_W-1:0];
      end else begin
        nxt.timer       = clamped[betb_pkg::TIMER_W-1:0];
      end
    end
  end

endmodule

// ===== sv/button_edge_and_autorepeat_table.sv =====
// Top level of the button edge and typematic auto-repeat table.
//
// Each item on req names a button, its latest event (release, press or none)
// and the frame time in microseconds. For every accepted item exactly one item
// leaves on rsp with the button's held, pressed, released, toggle and typed
// flags after the update. Per-button state sits in one table RAM with a
// registered read port.
// An item is read from the table at acceptance and its update is written back
// when it moves into the output register, so the result passes the read stage
// and then the output register. A write and a read of the same entry in one
// cycle are resolved by forwarding the written entry, so one item per cycle is
// sustained while rsp is ready. Reset clears the per-entry valid bits; an entry
// never written reads as all zero. When rsp stalls, the output register holds
// and one more item can wait in the read stage before req.ready drops.
// The user must write configuration through cfg_we/cfg_index/cfg_data only
// while no item is in flight; the block itself does not enforce this. With
// inputs_blocked set the table is left untouched and the stored flags are reported.
module button_edge_and_autorepeat_table #(
  parameter int unsigned BUTTON_COUNT = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  betb_req_if.sink                           req,
  betb_rsp_if.source                         rsp,
  input  logic                               cfg_we,
  input  logic [betb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [betb_pkg::TIME_W-1:0]        cfg_data
);

  localparam int unsigned AW = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

  // Configuration registers.
  logic [betb_pkg::TIME_W-1:0]   repeat_delay_us;
  logic [betb_pkg::TIME_W-1:0]   repeat_interval_us;
  logic                          inputs_blocked;

  // Read stage.
  logic                          s1_valid;
  logic [betb_pkg::IDX_W-1:0]    s1_idx;
  logic [betb_pkg::KIND_W-1:0]   s1_kind;
  logic [betb_pkg::TIME_W-1:0]   s1_elapsed;
  logic                          s1_inrange;
  logic [AW-1:0]                 s1_addr;
  logic                          fwd_hit;
  betb_pkg::entry_t              fwd_data;

  logic [BUTTON_COUNT-1:0]       entry_vld;
  logic                          accept;
  logic                          s1_adv;
  logic                          we;
  logic [31:0]                   req_idx_wide;
  logic [AW-1:0]                 req_addr;
  logic                          req_inrange;
  logic [betb_pkg::ENTRY_W-1:0]  ram_rdata;
  betb_pkg::entry_t              cur;
  betb_pkg::entry_t              nxt;
  betb_pkg::flags_t              rep_flags;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_delay_us    <= betb_pkg::REPEAT_DELAY_RST;
      repeat_interval_us <= betb_pkg::REPEAT_INTERVAL_RST;
      inputs_blocked     <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        betb_pkg::REG_REPEAT_DELAY:    repeat_delay_us    <= cfg_data;
        betb_pkg::REG_REPEAT_INTERVAL: repeat_interval_us <= cfg_data;
        betb_pkg::REG_INPUTS_BLOCKED:  inputs_blocked     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshake and address decode.
  always_comb begin
    s1_adv       = s1_valid && (!rsp.valid || rsp.ready);
    req.ready    = !s1_valid || s1_adv;
    accept       = req.valid && req.ready;
    we           = s1_adv && s1_inrange && !inputs_blocked;
    req_idx_wide = 32'(req.button_index);
    req_addr     = req_idx_wide[AW-1:0];
    req_inrange  = (req_idx_wide < BUTTON_COUNT);
  end

  betb_ram #(
    .WIDTH (betb_pkg::ENTRY_W),
    .DEPTH (BUTTON_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (s1_addr),
    .wdata (nxt),
    .re    (accept),
    .raddr (req_addr),
    .rdata (ram_rdata)
  );

  // Read stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // Read stage payload; catch a write to the same entry at the read edge.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx     <= req.button_index;
      s1_kind    <= req.event_kind;
      s1_elapsed <= req.elapsed_us;
      s1_inrange <= req_inrange;
      s1_addr    <= req_addr;
      fwd_hit    <= we && (s1_addr == req_addr);
      fwd_data   <= nxt;
    end
  end

  // Per-entry valid bits: an entry never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (we) begin
      entry_vld[s1_addr] <= 1'b1;
    end
  end

  // Select the current entry.
  always_comb begin
    if (!s1_inrange || !entry_vld[s1_addr]) begin
      cur = '0;
    end else if (fwd_hit) begin
      cur = fwd_data;
    end else begin
      cur = ram_rdata;
    end
  end

  betb_update u_update (
    .cur                (cur),
    .event_kind         (s1_kind),
    .elapsed_us         (s1_elapsed),
    .repeat_delay_us    (repeat_delay_us),
    .repeat_interval_us (repeat_interval_us),
    .nxt                (nxt)
  );

  // Reported flags: stored flags when blocked, zero beyond the table.
  always_comb begin
    if (!s1_inrange) begin
      rep_flags = '0;
    end else if (inputs_blocked) begin
      rep_flags = cur.flags;
    end else begin
      rep_flags = nxt.flags;
    end
  end

  // Output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (s1_adv) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp.button_id    <= s1_idx;
      rsp.is_held      <= rep_flags.held;
      rsp.was_pressed  <= rep_flags.pressed;
      rsp.was_released <= rep_flags.released;
      rsp.toggle_state <= rep_flags.toggle;
      rsp.typed_pulse  <= rep_flags.typed;
    end
  end

endmodule
